@@ sv/aill_pkg.sv @@
// shared types and constants for the archive index loader and lookup
// no dependencies
`default_nettype none
package aill_pkg;
    localparam int unsigned MaxEntries = 4096;
    localparam int unsigned AddrW = 12;
    localparam int unsigned CntW = 13;

    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_LOADING   = 3'd0;
    localparam logic [2:0] ST_READY     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_BAD_EXTRA = 3'd3;
    localparam logic [2:0] ST_BAD_NAMES = 3'd4;
    localparam logic [2:0] ST_TOO_MANY  = 3'd5;
    localparam logic [2:0] ST_IGNORED   = 3'd6;
    localparam logic [2:0] ST_LOOKUP    = 3'd7;

    localparam logic [31:0] MagicF2 = 32'd1414807858;
    localparam logic [31:0] MagicF3 = 32'd1414807859;
    localparam logic [31:0] MagicF4 = 32'd1414807860;
    localparam logic [31:0] ExtraLimit = 32'd15;
    localparam logic [31:0] NamesLimit = 32'h1000_0000;
    localparam logic [31:0] CountLimit = 32'd4096;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic [63:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic [2:0]      status;
        logic            found;
        logic [63:0]     entry_offset;
        logic [31:0]     entry_length;
        logic [15:0]     name_page;
        logic [15:0]     name_position;
        logic [1:0]      format_version;
        logic [CntW-1:0] name_page_count;
        logic [CntW-1:0] loaded_count;
    } t_out_item;
endpackage
`default_nettype wire

@@ sv/aill_queue.sv @@
// two-entry item queue between the front and back parts
// depends on aill_pkg
`default_nettype none
module aill_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire aill_pkg::t_in_item i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output aill_pkg::t_in_item      o_data,
    output logic                    o_empty
);
    aill_pkg::t_in_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

@@ sv/aill_back.sv @@
// back part: header parser, entry memories and binary search sequencer
// depends on aill_pkg
`default_nettype none
module aill_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire aill_pkg::t_in_item i_item,
    output logic                    o_take,
    output aill_pkg::t_out_item     o_res,
    output logic                    o_res_valid,
    input  wire logic               i_res_pop
);
    localparam logic [3:0] PH_MAGIC = 4'd0, PH_EXTRA = 4'd1, PH_NAMES = 4'd2,
        PH_COUNT = 4'd3, PH_KEY = 4'd4, PH_OFFSET = 4'd5, PH_SKIP_A = 4'd6,
        PH_SIZE = 4'd7, PH_SKIP_B = 4'd8, PH_PAGE = 4'd9, PH_POS = 4'd10,
        PH_DONE = 4'd11, PH_FAILED = 4'd12;
    localparam logic [1:0] S_IDLE = 2'd0, S_READ = 2'd1, S_CMP = 2'd2;
    localparam int unsigned AW = aill_pkg::AddrW;
    localparam int unsigned CW = aill_pkg::CntW;

    logic [63:0] r_key_mem [aill_pkg::MaxEntries];
    logic [63:0] r_off_mem [aill_pkg::MaxEntries];
    logic [31:0] r_len_mem [aill_pkg::MaxEntries];
    logic [15:0] r_pg_mem  [aill_pkg::MaxEntries];
    logic [15:0] r_pos_mem [aill_pkg::MaxEntries];

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_bidx, n_bidx;
    logic [63:0] r_acc, n_acc;
    logic [1:0]  r_fmt, n_fmt;
    logic [28:0] r_names, n_names;
    logic [CW-1:0] r_expected, n_expected, r_stored, n_stored;
    logic        r_ready, n_ready;
    logic [1:0]  r_st, n_st;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [63:0] r_skey, n_skey;
    logic [AW-1:0] r_mid, n_mid;
    logic [63:0] r_rk, r_ro;
    logic [31:0] r_rl;
    logic [15:0] r_rp, r_rq;
    logic        r_ov, n_ov;
    aill_pkg::t_out_item r_out, n_out;

    logic [63:0] acc;
    logic [31:0] w;
    logic [3:0]  nbytes;
    logic        last;
    logic [AW-1:0] slot;
    logic        can_emit;
    logic        hit, go_up, probe_done;

    assign can_emit = !r_ov || i_res_pop;
    assign o_take = i_valid && r_st == S_IDLE && can_emit;
    assign o_res = r_out;
    assign o_res_valid = r_ov;
    assign slot = r_stored[AW-1:0];

    assign hit = (r_rk == r_skey);
    assign go_up = (r_rk < r_skey);
    // a miss ends the search once the remaining range is empty
    assign probe_done = hit || (go_up ? ({1'b0, r_mid} + 1'b1 >= r_hi) :
                                        ({1'b0, r_mid} <= r_lo));

    always_comb begin
        acc = r_acc | ({56'd0, i_item.data_byte} << {r_bidx, 3'b000});
        w = acc[31:0];
        case (r_phase)
            PH_KEY, PH_OFFSET: nbytes = 4'd8;
            PH_PAGE, PH_POS:   nbytes = 4'd2;
            default:           nbytes = 4'd4;
        endcase
        last = ({1'b0, r_bidx} + 4'd1) == nbytes;
    end

    // store entry fields as they complete
    always_ff @(posedge i_clk) begin
        if (o_take && i_item.opcode == aill_pkg::OP_BYTE && r_phase < PH_DONE && last) begin
            if (r_phase == PH_KEY) r_key_mem[slot] <= acc;
            if (r_phase == PH_OFFSET) r_off_mem[slot] <= acc;
            if (r_phase == PH_SIZE) r_len_mem[slot] <= w;
            if (r_phase == PH_PAGE) r_pg_mem[slot] <= w[15:0];
            if (r_phase == PH_POS) r_pos_mem[slot] <= w[15:0];
        end
        r_rk <= r_key_mem[r_mid];
        r_ro <= r_off_mem[r_mid];
        r_rl <= r_len_mem[r_mid];
        r_rp <= r_pg_mem[r_mid];
        r_rq <= r_pos_mem[r_mid];
    end

    always_comb begin
        n_phase = r_phase;
        n_bidx = r_bidx;
        n_acc = r_acc;
        n_fmt = r_fmt;
        n_names = r_names;
        n_expected = r_expected;
        n_stored = r_stored;
        n_ready = r_ready;
        n_st = r_st;
        n_lo = r_lo;
        n_hi = r_hi;
        n_skey = r_skey;
        n_mid = r_mid;
        n_out = r_out;
        n_ov = r_ov;
        if (i_res_pop) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (o_take) begin
                    n_out = '0;
                    n_out.format_version = r_fmt;
                    n_out.name_page_count = r_names[28:16];
                    n_out.loaded_count = r_stored;
                    n_out.status = aill_pkg::ST_IGNORED;
                    n_ov = 1'b1;
                    case (i_item.opcode)
                        aill_pkg::OP_CLEAR: begin
                            n_phase = PH_MAGIC;
                            n_bidx = '0;
                            n_acc = '0;
                            n_fmt = '0;
                            n_names = '0;
                            n_expected = '0;
                            n_stored = '0;
                            n_ready = 1'b0;
                            n_out.status = aill_pkg::ST_LOADING;
                            n_out.format_version = '0;
                            n_out.name_page_count = '0;
                            n_out.loaded_count = '0;
                        end
                        aill_pkg::OP_LOOKUP: begin
                            if (r_ready && r_stored != '0) begin
                                n_ov = 1'b0;
                                n_skey = i_item.search_key;
                                n_lo = '0;
                                n_hi = r_stored;
                                n_mid = AW'((r_stored - 1'b1) >> 1);
                                n_st = S_READ;
                            end else begin
                                n_out.status = aill_pkg::ST_LOOKUP;
                            end
                        end
                        aill_pkg::OP_BYTE: begin
                            if (r_phase < PH_DONE) begin
                                n_out.status = aill_pkg::ST_LOADING;
                                if (!last) begin
                                    n_acc = acc;
                                    n_bidx = r_bidx + 3'd1;
                                end else begin
                                    n_acc = '0;
                                    n_bidx = '0;
                                    case (r_phase)
                                        PH_MAGIC: begin
                                            if (w == aill_pkg::MagicF2) begin
                                                n_fmt = 2'd0;
                                                n_out.format_version = 2'd0;
                                                n_phase = PH_EXTRA;
                                            end else if (w == aill_pkg::MagicF3) begin
                                                n_fmt = 2'd1;
                                                n_out.format_version = 2'd1;
                                                n_phase = PH_EXTRA;
                                            end else if (w == aill_pkg::MagicF4) begin
                                                n_fmt = 2'd2;
                                                n_out.format_version = 2'd2;
                                                n_phase = PH_NAMES;
                                            end else begin
                                                n_phase = PH_FAILED;
                                                n_out.status = aill_pkg::ST_BAD_MAGIC;
                                            end
                                        end
                                        PH_EXTRA: begin
                                            if (w > aill_pkg::ExtraLimit) begin
                                                n_phase = PH_FAILED;
                                                n_out.status = aill_pkg::ST_BAD_EXTRA;
                                            end else begin
                                                n_phase = PH_NAMES;
                                            end
                                        end
                                        PH_NAMES: begin
                                            if (w > aill_pkg::NamesLimit) begin
                                                n_phase = PH_FAILED;
                                                n_out.status = aill_pkg::ST_BAD_NAMES;
                                            end else begin
                                                n_names = w[28:0];
                                                n_out.name_page_count = w[28:16];
                                                n_phase = PH_COUNT;
                                            end
                                        end
                                        PH_COUNT: begin
                                            if (w > aill_pkg::CountLimit) begin
                                                n_phase = PH_FAILED;
                                                n_out.status = aill_pkg::ST_TOO_MANY;
                                            end else if (w == 32'd0) begin
                                                n_expected = '0;
                                                n_phase = PH_DONE;
                                                n_ready = 1'b1;
                                                n_out.status = aill_pkg::ST_READY;
                                            end else begin
                                                n_expected = w[CW-1:0];
                                                n_phase = PH_KEY;
                                            end
                                        end
                                        PH_KEY: n_phase = PH_OFFSET;
                                        PH_OFFSET: n_phase = (r_fmt == 2'd0) ?
                                            PH_SKIP_A : PH_SIZE;
                                        PH_SKIP_A: n_phase = PH_SIZE;
                                        PH_SIZE: n_phase = PH_SKIP_B;
                                        PH_SKIP_B: n_phase = PH_PAGE;
                                        PH_PAGE: n_phase = PH_POS;
                                        PH_POS: begin
                                            n_stored = r_stored + 1'b1;
                                            n_out.loaded_count = r_stored + 1'b1;
                                            if (r_stored + 1'b1 >= r_expected) begin
                                                n_phase = PH_DONE;
                                                n_ready = 1'b1;
                                                n_out.status = aill_pkg::ST_READY;
                                            end else begin
                                                n_phase = PH_KEY;
                                            end
                                        end
                                        default: n_phase = PH_FAILED;
                                    endcase
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: n_st = S_CMP;
            S_CMP: begin
                // a hit or an empty remaining range ends the search, otherwise narrow the range
                if (probe_done) begin
                    if (can_emit) begin
                        n_out.status = aill_pkg::ST_LOOKUP;
                        n_out.found = hit;
                        n_out.entry_offset = hit ? r_ro : '0;
                        n_out.entry_length = hit ? r_rl : '0;
                        n_out.name_page = hit ? r_rp : '0;
                        n_out.name_position = hit ? r_rq : '0;
                        n_out.format_version = r_fmt;
                        n_out.name_page_count = r_names[28:16];
                        n_out.loaded_count = r_stored;
                        n_ov = 1'b1;
                        n_st = S_IDLE;
                    end
                end else begin
                    if (go_up) begin
                        n_lo = {1'b0, r_mid} + 1'b1;
                        n_mid = AW'(({1'b0, r_mid} + r_hi) >> 1);
                    end else begin
                        n_hi = {1'b0, r_mid};
                        n_mid = AW'((r_lo + {1'b0, r_mid} - 1'b1) >> 1);
                    end
                    n_st = S_READ;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_bidx <= '0;
            r_acc <= '0;
            r_fmt <= '0;
            r_names <= '0;
            r_expected <= '0;
            r_stored <= '0;
            r_ready <= 1'b0;
            r_st <= S_IDLE;
            r_lo <= '0;
            r_hi <= '0;
            r_skey <= '0;
            r_mid <= '0;
            r_out <= '0;
            r_ov <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bidx <= n_bidx;
            r_acc <= n_acc;
            r_fmt <= n_fmt;
            r_names <= n_names;
            r_expected <= n_expected;
            r_stored <= n_stored;
            r_ready <= n_ready;
            r_st <= n_st;
            r_lo <= n_lo;
            r_hi <= n_hi;
            r_skey <= n_skey;
            r_mid <= n_mid;
            r_out <= n_out;
            r_ov <= n_ov;
        end
    end
endmodule
`default_nettype wire

@@ sv/archive_index_loader_and_lookup.sv @@
// top level: input queue feeding the header parser and lookup back part
// depends on aill_pkg, aill_queue, aill_back
//
// usage: items enter through a queue-like port (push/full) and each item
// gives exactly one result on a queue-like port (empty/pop).
// opcode 0 feeds one header byte, 1 looks up a key, 2 clears the load.
// a header byte or clear is done in the back part as it is taken, so one item a
// cycle while pop keeps up; a lookup takes a memory read, then a compare, per
// binary-search probe, at most 13 probes over a 4096-entry table, and the
// next item is taken only once its result has been emitted.
// a byte or clear result shows on empty low in the cycle after it is taken.
// a two-entry queue decouples input from the back part.
// reset (synchronous, active low) empties the queue, drops any pending
// result and returns the parser to awaiting the magic word; the entry
// memories are not cleared and need no clearing pass.
// when the receiver holds pop low, the result register holds, the back part
// stops, and the input queue fills and then raises full.
`default_nettype none
module archive_index_loader_and_lookup (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    input  wire aill_pkg::t_in_item  i_item,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output aill_pkg::t_out_item      o_item
);
    aill_pkg::t_in_item q_data;
    logic q_empty, take, res_valid;

    aill_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(i_item), .o_full(full),
        .i_pop(take), .o_data(q_data), .o_empty(q_empty)
    );

    aill_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!q_empty), .i_item(q_data), .o_take(take),
        .o_res(o_item), .o_res_valid(res_valid), .i_res_pop(pop)
    );

    assign empty = !res_valid;
endmodule
`default_nettype wire

@@ tb/archive_index_loader_and_lookup_tb.sv @@
// testbench for the archive index loader and lookup block
// depends on aill_pkg and archive_index_loader_and_lookup; predicts every result
// and checks it field by field, with random idling on both sides
`default_nettype none
module archive_index_loader_and_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        P_MAGIC, P_EXTRA, P_NAMES, P_COUNT, P_KEY, P_OFFSET, P_SKIP_A,
        P_SIZE, P_SKIP_B, P_PAGE, P_POS, P_DONE, P_FAILED
    } t_phase;

    localparam int CycleLimit = 1500000;

    logic i_clk;
    logic i_rst_n;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    aill_pkg::t_in_item cur_item = '0;
    aill_pkg::t_out_item o_item;

    archive_index_loader_and_lookup DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .i_item (cur_item),
        .full   (full),
        .pop    (pop),
        .empty  (empty),
        .o_item (o_item)
    );

    // predictor state
    t_phase       phase;
    int unsigned  byte_idx;
    logic [63:0]  acc;
    logic [1:0]   fmt;
    logic [31:0]  names_size;
    logic [31:0]  want_count;
    logic [31:0]  stored;
    logic         ready;
    logic [63:0]  key_mem [aill_pkg::MaxEntries];
    logic [63:0]  off_mem [aill_pkg::MaxEntries];
    logic [31:0]  len_mem [aill_pkg::MaxEntries];
    logic [15:0]  page_mem [aill_pkg::MaxEntries];
    logic [15:0]  pos_mem [aill_pkg::MaxEntries];

    aill_pkg::t_in_item  pending_items[$];
    aill_pkg::t_out_item expected_results[$];
    logic [63:0] table_keys[$];
    int errors = 0;
    int cycles = 0;
    int n_lookups = 0;
    int n_hits = 0;
    int n_loads = 0;
    int n_results = 0;

    task automatic report(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic void restart_load();
        phase = P_MAGIC;
        byte_idx = 0;
        acc = '0;
        fmt = '0;
        names_size = '0;
        want_count = '0;
        stored = '0;
        ready = 1'b0;
    endfunction

    function automatic logic [2:0] parse_byte(input logic [7:0] b);
        t_phase ph;
        int unsigned nbytes;
        logic [63:0] v;
        logic [31:0] w;
        logic [11:0] slot;
        ph = phase;
        if (ph == P_DONE || ph == P_FAILED) return aill_pkg::ST_IGNORED;
        acc |= 64'(b) << (8 * (byte_idx & 7));
        byte_idx++;
        nbytes = (ph == P_KEY || ph == P_OFFSET) ? 8 : (ph == P_PAGE || ph == P_POS) ? 2 : 4;
        if (byte_idx < nbytes) return aill_pkg::ST_LOADING;
        v = acc;
        w = v[31:0];
        acc = '0;
        byte_idx = 0;
        slot = 12'(stored);
        case (ph)
            P_MAGIC: begin
                if (w == aill_pkg::MagicF2) begin
                    fmt = 2'd0; phase = P_EXTRA;
                end else if (w == aill_pkg::MagicF3) begin
                    fmt = 2'd1; phase = P_EXTRA;
                end else if (w == aill_pkg::MagicF4) begin
                    fmt = 2'd2; phase = P_NAMES;
                end else begin
                    phase = P_FAILED;
                    return aill_pkg::ST_BAD_MAGIC;
                end
            end
            P_EXTRA: begin
                if (w > aill_pkg::ExtraLimit) begin
                    phase = P_FAILED;
                    return aill_pkg::ST_BAD_EXTRA;
                end
                phase = P_NAMES;
            end
            P_NAMES: begin
                if (w > aill_pkg::NamesLimit) begin
                    phase = P_FAILED;
                    return aill_pkg::ST_BAD_NAMES;
                end
                names_size = w;
                phase = P_COUNT;
            end
            P_COUNT: begin
                if (w > aill_pkg::MaxEntries) begin
                    phase = P_FAILED;
                    return aill_pkg::ST_TOO_MANY;
                end
                want_count = w;
                if (w == 0) begin
                    phase = P_DONE;
                    ready = 1'b1;
                    return aill_pkg::ST_READY;
                end
                phase = P_KEY;
            end
            P_KEY: begin
                key_mem[slot] = v; phase = P_OFFSET;
            end
            P_OFFSET: begin
                off_mem[slot] = v;
                phase = (fmt == 2'd0) ? P_SKIP_A : P_SIZE;
            end
            P_SKIP_A: phase = P_SIZE;
            P_SIZE: begin
                len_mem[slot] = w; phase = P_SKIP_B;
            end
            P_SKIP_B: phase = P_PAGE;
            P_PAGE: begin
                page_mem[slot] = w[15:0]; phase = P_POS;
            end
            default: begin
                pos_mem[slot] = w[15:0];
                stored++;
                if (stored >= want_count) begin
                    phase = P_DONE;
                    ready = 1'b1;
                    return aill_pkg::ST_READY;
                end
                phase = P_KEY;
            end
        endcase
        return aill_pkg::ST_LOADING;
    endfunction

    function automatic aill_pkg::t_out_item predict_result(input aill_pkg::t_in_item it);
        aill_pkg::t_out_item r;
        int lo;
        int hi;
        int mid;
        logic [11:0] m;
        r = '0;
        r.status = aill_pkg::ST_IGNORED;
        if (it.opcode == aill_pkg::OP_BYTE) begin
            r.status = parse_byte(it.data_byte);
        end else if (it.opcode == aill_pkg::OP_LOOKUP) begin
            r.status = aill_pkg::ST_LOOKUP;
            n_lookups++;
            if (ready) begin
                lo = 0;
                hi = int'(stored);
                while (lo < hi) begin
                    mid = (lo + hi - 1) >> 1;
                    m = 12'(mid);
                    if (key_mem[m] == it.search_key) begin
                        r.found = 1'b1;
                        r.entry_offset = off_mem[m];
                        r.entry_length = len_mem[m];
                        r.name_page = page_mem[m];
                        r.name_position = pos_mem[m];
                        n_hits++;
                        break;
                    end
                    if (key_mem[m] < it.search_key) lo = mid + 1;
                    else hi = mid;
                end
            end
        end else if (it.opcode == aill_pkg::OP_CLEAR) begin
            restart_load();
            r.status = aill_pkg::ST_LOADING;
        end
        r.format_version = fmt;
        r.name_page_count = aill_pkg::CntW'(names_size >> 16);
        r.loaded_count = aill_pkg::CntW'(stored);
        return r;
    endfunction

    // stimulus helpers
    task automatic put(input logic [1:0] op, input logic [7:0] b, input logic [63:0] k);
        aill_pkg::t_in_item it;
        it.opcode = op;
        it.data_byte = b;
        it.search_key = k;
        pending_items = {pending_items, it};
    endtask

    task automatic put_le(input logic [63:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            put(aill_pkg::OP_BYTE, v[8*i +: 8], {$urandom, $urandom});
    endtask

    task automatic put_header(input int f, input logic [31:0] extra, input logic [31:0] names,
                              input logic [31:0] count);
        put_le(f == 0 ? aill_pkg::MagicF2 : f == 1 ? aill_pkg::MagicF3 : aill_pkg::MagicF4, 4);
        if (f != 2) put_le(extra, 4);
        put_le(names, 4);
        put_le(count, 4);
    endtask

    task automatic put_entry(input int f, input logic [63:0] k);
        put_le(k, 8);
        put_le({$urandom, $urandom}, 8);
        if (f == 0) put_le($urandom, 4);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le($urandom, 2);
    endtask

    // full well-formed load with ascending keys, duplicates now and then
    task automatic put_table(input int f, input int n);
        logic [63:0] k;
        table_keys.delete();
        put(aill_pkg::OP_CLEAR, 8'($urandom), {$urandom, $urandom});
        put_header(f, $urandom_range(15), $urandom_range(32'h1000_0000), n);
        k = {$urandom, $urandom} >> $urandom_range(8, 63);
        for (int i = 0; i < n; i++) begin
            table_keys = {table_keys, k};
            put_entry(f, k);
            if ($urandom_range(9) != 0) k += (({$urandom, $urandom} >> 20) + 1);
        end
        n_loads++;
    endtask

    task automatic put_lookup();
        logic [63:0] k;
        int sel;
        sel = $urandom_range(9);
        k = {$urandom, $urandom};
        if (table_keys.size() > 0 && sel < 5) k = table_keys[$urandom_range(table_keys.size() - 1)];
        else if (table_keys.size() > 0 && sel < 7)
            k = table_keys[$urandom_range(table_keys.size() - 1)] +
                64'($urandom_range(1) ? 1 : -1);
        put(aill_pkg::OP_LOOKUP, 8'($urandom), k);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || push || expected_results.size() != 0);
    endtask

    // idling stays off for a long stretch in the middle of the run
    function automatic logic idle_roll();
        if (cycles > 600 && cycles < 1200) return 1'b0;
        return $urandom_range(99) < 15;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("archive_index_loader_and_lookup regression: fail");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            restart_load();
        end else begin
            if (push && !full) expected_results = {expected_results, predict_result(cur_item)};
            if (!push || !full) begin
                if (pending_items.size() != 0 && !idle_roll()) begin
                    cur_item <= pending_items.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string nm, input logic [63:0] got, input logic [63:0] want);
        if (got !== want) report($sformatf("%s got %0h expected %0h", nm, got, want));
    endtask

    // monitor
    always @(posedge i_clk) begin
        aill_pkg::t_out_item w;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    w = expected_results.pop_front();
                    n_results++;
                    check_field("status", o_item.status, w.status);
                    check_field("found", o_item.found, w.found);
                    check_field("entry_offset", o_item.entry_offset, w.entry_offset);
                    check_field("entry_length", o_item.entry_length, w.entry_length);
                    check_field("name_page", o_item.name_page, w.name_page);
                    check_field("name_position", o_item.name_position, w.name_position);
                    check_field("format_version", o_item.format_version, w.format_version);
                    check_field("name_page_count", o_item.name_page_count, w.name_page_count);
                    check_field("loaded_count", o_item.loaded_count, w.loaded_count);
                end
            end
            pop <= !idle_roll();
        end
    end

    initial begin
        int f;
        int n;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lookup before ready, unused opcode, each header error
        put(aill_pkg::OP_LOOKUP, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
        put(aill_pkg::OP_UNUSED, 8'hFF, 64'h0);
        put_le(32'hFFFF_FFFF, 4);
        put(aill_pkg::OP_BYTE, 8'h5A, 64'h0);
        put(aill_pkg::OP_CLEAR, 8'h00, 64'h0);
        put_header(1, 32'd16, 0, 0);
        put(aill_pkg::OP_CLEAR, 8'h00, 64'h0);
        put_header(2, 0, 32'h1000_0001, 0);
        put(aill_pkg::OP_CLEAR, 8'h00, 64'h0);
        put_header(0, 15, 32'h1000_0000, 32'd4097);
        put(aill_pkg::OP_CLEAR, 8'h00, 64'h0);
        put_header(2, 0, 32'h0, 32'hFFFF_FFFF);
        put(aill_pkg::OP_CLEAR, 8'h00, 64'h0);
        put_header(2, 0, 32'h1000_0000, 0);
        put(aill_pkg::OP_LOOKUP, 8'h00, 64'h0);
        put(aill_pkg::OP_BYTE, 8'h11, 64'h0);
        // extreme keys, with a clear in the middle of the first load
        put(aill_pkg::OP_CLEAR, 8'h00, 64'h0);
        put_header(0, 0, 32'h0001_0000, 3);
        put_entry(0, 64'h0);
        put(aill_pkg::OP_CLEAR, 8'h00, 64'h0);
        put_header(0, 0, 32'h0001_0000, 3);
        put_entry(0, 64'h0);
        put_entry(0, 64'h5);
        put_entry(0, 64'hFFFF_FFFF_FFFF_FFFF);
        table_keys = '{64'h0, 64'h5, 64'hFFFF_FFFF_FFFF_FFFF};
        put(aill_pkg::OP_LOOKUP, 8'h00, 64'h0);
        put(aill_pkg::OP_LOOKUP, 8'h00, 64'h5);
        put(aill_pkg::OP_LOOKUP, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
        put(aill_pkg::OP_LOOKUP, 8'h00, 64'h4);
        put(aill_pkg::OP_BYTE, 8'h00, 64'h0);
        wait_drained();

        // one larger table, then small random tables
        put_table(1, 12);
        for (int i = 0; i < 40; i++) put_lookup();
        while (pending_items.size() != 0) @(negedge i_clk);
        for (int r = 0; r < 5; r++) begin
            f = $urandom_range(2);
            n = $urandom_range(1, 4);
            if ($urandom_range(9) == 0) begin
                // broken or cut-short header, then noise
                put(aill_pkg::OP_CLEAR, 8'($urandom), {$urandom, $urandom});
                put_le({$urandom, $urandom}, $urandom_range(1, 8));
                table_keys.delete();
            end else begin
                put_table(f, n);
            end
            for (int i = $urandom_range(4, 16); i > 0; i--) begin
                case ($urandom_range(19))
                    0: put(aill_pkg::OP_UNUSED, 8'($urandom), {$urandom, $urandom});
                    1: put(aill_pkg::OP_BYTE, 8'($urandom), {$urandom, $urandom});
                    default: put_lookup();
                endcase
            end
            if (r == 2) wait_drained();
        end
        wait_drained();
        repeat (60) @(posedge i_clk);

        $display("covered %0d table loads, %0d lookups with %0d hits, %0d results checked",
                 n_loads, n_lookups, n_hits, n_results);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("archive_index_loader_and_lookup regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_results.size());
            $display("archive_index_loader_and_lookup regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
